// ----- hdl/ouks_pkg.sv -----
// ouks_pkg: request and status codes and fixed field widths for the
// ordered unique key set. No dependencies.
package ouks_pkg;

  // fixed field widths
  localparam int REQ_W    = 2;
  localparam int POS_BITS = 6;
  localparam int STATUS_W = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOCATE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_PICKUP = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

endpackage

// ----- hdl/ouks_ram.sv -----
// ouks_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module ouks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ouks_mod.sv -----
// ouks_mod: bit-serial restoring remainder unit, one dividend bit a cycle.
// No dependencies.
module ouks_mod #(
  parameter int DVD_W = 6,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVS_W-1:0] remainder
);

  localparam int CB = $clog2(DVD_W + 1);

  logic             busy;
  logic [CB-1:0]    cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_next;

  // one restoring step on the next dividend bit
  assign trial    = {remainder, dvd[DVD_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CB'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CB'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CB'(1);
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= dvd << 1;
      remainder <= rem_next;
    end
  end

endmodule

// ----- hdl/ordered_unique_key_set_top.sv -----
// ordered_unique_key_set_top: sequencer around the entry memory and the
// remainder unit. Depends on ouks_pkg, ouks_ram and ouks_mod.
//
// An insertion-ordered set of up to CAPACITY unique keys kept compacted in
// one synchronous RAM. One item at a time is taken; every item yields one
// result item. The RAM has one read and one write port, so the time per
// item is set by walking its entries one a cycle: insert, locate and
// remove first scan the current entries, stopping early when the key is
// found; a remove that finds its key and every pickup on a non-empty set
// then shift the later entries down one place, one entry a cycle. Pickup
// on a non-empty set first reduces the position modulo the count in a
// bit-serial unit and reads the taken entry. A final state loads the
// output register, which holds a result while the far side stalls; the
// next item is taken the cycle after. After reset the set is empty and
// items are taken at once.
module ordered_unique_key_set_top
  import ouks_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 6,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [KEY_BITS-1:0] key,
  input  logic [POS_BITS-1:0] position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [IDX_W-1:0]    found_index,
  output logic [KEY_BITS-1:0] taken_key,
  output logic [CNT_W-1:0]    entry_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_TAKE  = 3'd3;
  localparam logic [2:0] S_TAKEW = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state;
  logic [REQ_W-1:0]    req_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr;
  logic                pend;
  logic [IDX_W-1:0]    pend_idx;
  logic [IDX_W-1:0]    where;
  logic [STATUS_W-1:0] st_q;
  logic [IDX_W-1:0]    idx_q;
  logic [KEY_BITS-1:0] taken_q;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [KEY_BITS-1:0] rd_data;

  logic                mod_start;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;

  logic                accept;
  logic                issue;
  logic                hit;
  logic                walk_end;
  logic                full;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign issue    = (ptr < count);
  assign hit      = pend && (rd_data == key_q);
  assign walk_end = !pend && !issue;
  assign full     = (count == CNT_W'(CAPACITY));

  assign mod_start = accept && (req_type == REQ_PICKUP) && (count != '0);

  // memory port control: append on insert, move down during shift
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = key_q;
    if (state == S_SHIFT) begin
      mem_we    = pend;
      mem_waddr = pend_idx - IDX_W'(1);
      mem_wdata = rd_data;
    end else if (state == S_SCAN) begin
      mem_we = !hit && walk_end && (req_q == REQ_INSERT) && !full;
    end
    mem_raddr = (state == S_TAKE) ? where : ptr[IDX_W-1:0];
  end

  ouks_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rd_data)
  );

  ouks_mod #(
    .DVD_W(POS_BITS),
    .DVS_W(CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (position),
    .divisor  (count),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          pend <= 1'b0;
          ptr  <= '0;
          if (accept) begin
            if (req_type == REQ_PICKUP) begin
              state <= (count == '0) ? S_DONE : S_MOD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        // compare entries one a cycle against the key
        S_SCAN: begin
          if (hit && (req_q == REQ_REMOVE)) begin
            ptr   <= CNT_W'(pend_idx) + CNT_W'(1);
            pend  <= 1'b0;
            state <= S_SHIFT;
          end else begin
            pend <= issue;
            if (issue) begin
              ptr <= ptr + CNT_W'(1);
            end
            if (hit) begin
              state <= S_DONE;
            end else if (walk_end) begin
              if ((req_q == REQ_INSERT) && !full) begin
                count <= count + CNT_W'(1);
              end
              state <= S_DONE;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          state <= S_TAKEW;
        end
        S_TAKEW: begin
          ptr   <= CNT_W'(where) + CNT_W'(1);
          pend  <= 1'b0;
          state <= S_SHIFT;
        end
        // move later entries down one place
        S_SHIFT: begin
          pend <= issue;
          if (issue) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (walk_end) begin
            count <= count - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and result fields
  always_ff @(posedge clk) begin
    pend_idx <= ptr[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_q   <= req_type;
          key_q   <= key;
          st_q    <= ((req_type == REQ_PICKUP) && (count == '0)) ? ST_EMPTY : ST_OK;
          idx_q   <= '0;
          taken_q <= '0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          where <= pend_idx;
          if (req_q == REQ_INSERT) begin
            st_q <= ST_DUP;
          end else begin
            idx_q <= pend_idx;
          end
        end else if (walk_end) begin
          if (req_q != REQ_INSERT) begin
            st_q <= ST_ABSENT;
          end else if (full) begin
            st_q <= ST_FULL;
          end else begin
            idx_q <= count[IDX_W-1:0];
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          where <= mod_rem[IDX_W-1:0];
          idx_q <= mod_rem[IDX_W-1:0];
        end
      end
      S_TAKEW: begin
        taken_q <= rd_data;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          status      <= st_q;
          found_index <= idx_q;
          taken_key   <= taken_q;
          entry_count <= count;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- dv/ordered_unique_key_set_top_tb.sv -----
// ordered_unique_key_set_top_tb: self-checking testbench for the ordered unique key set.
// Depends on ouks_pkg and ordered_unique_key_set_top; tracks its own copy of the set
// and checks every result item against it.
module ordered_unique_key_set_top_tb;
  import ouks_pkg::*;

  localparam int CAP         = 64;
  localparam int KEY_W       = 6;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int N_ITEMS     = 1150;
  localparam int IDLE_PCT    = 34;
  localparam int CALM_LO     = 400;
  localparam int CALM_HI     = 600;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic [REQ_W-1:0]    req;
    logic [KEY_W-1:0]    key;
    logic [POS_BITS-1:0] pos;
    bit                  drain_first;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    found_index;
    logic [KEY_W-1:0]    taken_key;
    logic [CNT_W-1:0]    entry_count;
  } set_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    req_type = '0;
  logic [KEY_W-1:0]    key = '0;
  logic [POS_BITS-1:0] position = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    found_index;
  logic [KEY_W-1:0]    taken_key;
  logic [CNT_W-1:0]    entry_count;

  request_t   requests_todo[$];
  set_reply_t replies_due[$];
  request_t   cur_req;
  int         n_sent = 0;
  int         n_recv = 0;
  int         n_errors = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         quiet_cycles = 0;

  // shadow copy of the set
  logic [KEY_W-1:0] set_keys[CAP];
  int               set_count = 0;

  ordered_unique_key_set_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .key         (key),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index),
    .taken_key   (taken_key),
    .entry_count (entry_count)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reset at the start only
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // apply one request to the shadow set and return the reply it should give
  function automatic set_reply_t next_reply(request_t r);
    set_reply_t rep;
    int         slot;
    int         j;
    bit         hit;
    bit         drop;
    rep.status      = ST_OK;
    rep.found_index = '0;
    rep.taken_key   = '0;
    slot = 0;
    hit  = 1'b0;
    drop = 1'b0;
    for (j = 0; j < set_count; j++) begin
      if (!hit && set_keys[j] == r.key) begin
        hit  = 1'b1;
        slot = j;
      end
    end
    case (r.req)
      REQ_INSERT: begin
        if (hit) begin
          rep.status = ST_DUP;
        end else if (set_count >= CAP) begin
          rep.status = ST_FULL;
        end else begin
          set_keys[set_count] = r.key;
          rep.found_index = IDX_W'(set_count);
          set_count++;
        end
      end
      REQ_REMOVE: begin
        if (hit) begin
          rep.found_index = IDX_W'(slot);
          drop = 1'b1;
        end else begin
          rep.status = ST_ABSENT;
        end
      end
      REQ_LOCATE: begin
        if (hit) rep.found_index = IDX_W'(slot);
        else rep.status = ST_ABSENT;
      end
      default: begin
        if (set_count == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          slot = int'(r.pos) % set_count;
          rep.taken_key   = set_keys[slot];
          rep.found_index = IDX_W'(slot);
          drop = 1'b1;
        end
      end
    endcase
    // compaction: later entries move down one place
    if (drop) begin
      for (j = slot; j < set_count - 1; j++) set_keys[j] = set_keys[j + 1];
      set_count--;
    end
    rep.entry_count = CNT_W'(set_count);
    return rep;
  endfunction

  task automatic add_request(logic [REQ_W-1:0] req, int k, int p);
    request_t r;
    r.req = req;
    r.key = KEY_W'(k);
    r.pos = POS_BITS'(p);
    r.drain_first = 1'b0;
    requests_todo.push_back(r);
  endtask

  // stimulus and end of run
  initial begin
    int seg;
    int n;
    int i;
    int j;
    int tmp;
    int w;
    int total;
    int perm[CAP];

    // directed: empty set, duplicates, misses, compaction, pickup wrap
    add_request(REQ_PICKUP, 0, 63);
    add_request(REQ_REMOVE, 5, 0);
    add_request(REQ_LOCATE, 0, 0);
    add_request(REQ_INSERT, 0, 0);
    add_request(REQ_INSERT, 63, 0);
    add_request(REQ_INSERT, 42, 0);
    add_request(REQ_INSERT, 63, 0);
    add_request(REQ_LOCATE, 63, 0);
    add_request(REQ_LOCATE, 7, 0);
    add_request(REQ_REMOVE, 0, 0);
    add_request(REQ_LOCATE, 42, 0);
    add_request(REQ_REMOVE, 0, 0);
    add_request(REQ_PICKUP, 0, 63);
    add_request(REQ_PICKUP, 0, 0);
    add_request(REQ_PICKUP, 0, 0);
    add_request(REQ_INSERT, 21, 0);
    add_request(REQ_PICKUP, 0, 0);
    add_request(REQ_REMOVE, 21, 0);

    // random segments
    while (requests_todo.size() < N_ITEMS) begin
      seg = $urandom_range(0, 9);
      if (seg == 0) begin
        // fill to capacity with every key, then probe and empty it
        for (i = 0; i < CAP; i++) perm[i] = i;
        for (i = 0; i < CAP - 1; i++) begin
          j = $urandom_range(CAP - 1, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (i = 0; i < CAP; i++) add_request(REQ_INSERT, perm[i], $urandom_range(63));
        repeat (4) add_request(REQ_INSERT, $urandom_range(63), $urandom_range(63));
        repeat (6) add_request(REQ_LOCATE, $urandom_range(63), $urandom_range(63));
        repeat (4) add_request(REQ_REMOVE, $urandom_range(63), $urandom_range(63));
        repeat (CAP + 2) add_request(REQ_PICKUP, $urandom_range(63), $urandom_range(63));
      end else if (seg <= 2) begin
        // pickup run, often down to empty
        n = $urandom_range(70, 20);
        repeat (n) add_request(REQ_PICKUP, $urandom_range(63), $urandom_range(63));
      end else if (seg <= 4) begin
        // insert run
        n = $urandom_range(30, 5);
        repeat (n) add_request(REQ_INSERT, $urandom_range(63), $urandom_range(63));
      end else begin
        // mixed requests
        n = $urandom_range(40, 10);
        repeat (n) begin
          w = $urandom_range(99);
          if (w < 35) add_request(REQ_INSERT, $urandom_range(63), $urandom_range(63));
          else if (w < 55) add_request(REQ_REMOVE, $urandom_range(63), $urandom_range(63));
          else if (w < 80) add_request(REQ_LOCATE, $urandom_range(63), $urandom_range(63));
          else add_request(REQ_PICKUP, $urandom_range(63), $urandom_range(63));
        end
      end
    end
    // sender waits for all results before these items
    requests_todo[700].drain_first = 1'b1;
    requests_todo[1000].drain_first = 1'b1;
    total = requests_todo.size();

    while (n_sent < total || replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0 && replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // driver: predict on accept, then offer the next item or idle
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(next_reply(cur_req));
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        offer = requests_todo.size() != 0;
        if (offer) begin
          if (requests_todo[0].drain_first && n_recv != n_sent) offer = 1'b0;
        end
        if (offer && !(n_sent >= CALM_LO && n_sent < CALM_HI) &&
            $urandom_range(99) < IDLE_PCT) offer = 1'b0;
        if (offer) begin
          cur_req = requests_todo.pop_front();
          req_type <= cur_req.req;
          key      <= cur_req.key;
          position <= cur_req.pos;
        end
        in_valid <= offer;
      end
    end
  end

  // monitor: check each result item, drive the receiver stall
  always @(posedge clk) begin
    set_reply_t want;
    int         got;
    bit         hold;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      got = n_recv;
      if (out_valid && !out_stall) begin
        got = n_recv + 1;
        if (replies_due.size() == 0) begin
          $error("result item with no request pending: status %0d", status);
          n_errors++;
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            n_errors++;
          end
          if (found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index, found_index);
            n_errors++;
          end
          if (taken_key !== want.taken_key) begin
            $error("taken_key: expected %0d, got %0d", want.taken_key, taken_key);
            n_errors++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
            n_errors++;
          end
        end
      end
      n_recv <= got;
      // one long hold-off so the block backs up, else random stalls
      if (hold_left != 0) begin
        hold_left--;
        hold = 1'b1;
      end else if (got == HOLD_AT && !hold_done) begin
        hold_left = HOLD_LEN - 1;
        hold_done = 1'b1;
        hold = 1'b1;
      end else begin
        hold = !(got >= CALM_LO && got < CALM_HI) && $urandom_range(99) < IDLE_PCT;
      end
      out_stall <= hold;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ----- ordered_unique_key_set_top.f -----
hdl/ouks_pkg.sv
hdl/ouks_ram.sv
hdl/ouks_mod.sv
hdl/ordered_unique_key_set_top.sv
dv/ordered_unique_key_set_top_tb.sv
